// File: design/qts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_pkg
// Shared types and constants for the quoted token splitter.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // result queue depth: two entries per byte plus slack for back-to-back flow
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    MODE_SPACE  = 4'b0001,
    MODE_PLAIN  = 4'b0010,
    MODE_SQUOTE = 4'b0100,
    MODE_DQUOTE = 4'b1000
  } qts_mode_e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       token_end;
    logic       line_end;
    logic       run_last;
  } qts_res_t;

  // what one byte produces: up to two results plus the next parse state
  typedef struct packed {
    logic [1:0] num;
    qts_res_t   res0;
    qts_res_t   res1;
    qts_mode_e  mode_nxt;
    logic       has_bytes_nxt;
  } qts_step_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             not_empty;
  } qts_qstat_t;

endpackage

// File: design/qts_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_parse
// Combinational per-byte tokenizer step: results and next parse state.
// ----------------------------------------------------------------------------
module qts_parse (
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  qts_pkg::qts_mode_e  mode_i,
  input  logic                has_bytes_i,
  output qts_pkg::qts_step_t  step_o
);
  import qts_pkg::*;

  logic      blank;
  logic      closer_hit;
  logic      have0;
  qts_res_t  r0;
  qts_res_t  rline;
  qts_mode_e mode_mid;
  logic      hb_mid;

  always_comb begin
    blank      = (byte_i inside {[8'h09:8'h0d], 8'h20});
    closer_hit = ((mode_i == MODE_SQUOTE) && (byte_i == CH_SQUOTE)) ||
                 ((mode_i == MODE_DQUOTE) && (byte_i == CH_DQUOTE));
    have0      = 1'b0;
    r0         = '0;
    mode_mid   = mode_i;
    hb_mid     = has_bytes_i;

    case (mode_i)
      MODE_SPACE: begin
        if (!blank) begin
          if (byte_i == CH_SQUOTE) begin
            mode_mid = MODE_SQUOTE;
            hb_mid   = 1'b0;
          end else if (byte_i == CH_DQUOTE) begin
            mode_mid = MODE_DQUOTE;
            hb_mid   = 1'b0;
          end else begin
            have0         = 1'b1;
            r0.byte_out   = byte_i;
            r0.byte_valid = 1'b1;
            mode_mid      = MODE_PLAIN;
            hb_mid        = 1'b1;
          end
        end
      end
      MODE_PLAIN: begin
        if (blank) begin
          have0        = has_bytes_i;
          r0.token_end = has_bytes_i;
          mode_mid     = MODE_SPACE;
          hb_mid       = 1'b0;
        end else begin
          have0         = 1'b1;
          r0.byte_out   = byte_i;
          r0.byte_valid = 1'b1;
          hb_mid        = 1'b1;
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (closer_hit) begin
          have0        = has_bytes_i;
          r0.token_end = has_bytes_i;
          mode_mid     = MODE_SPACE;
          hb_mid       = 1'b0;
        end else begin
          have0         = 1'b1;
          r0.byte_out   = byte_i;
          r0.byte_valid = 1'b1;
          hb_mid        = 1'b1;
        end
      end
      default: begin
        mode_mid = MODE_SPACE;
        hb_mid   = 1'b0;
      end
    endcase

    // line end result flushes any open token, quoted or not
    rline           = '0;
    rline.token_end = hb_mid;
    rline.line_end  = 1'b1;
    rline.run_last  = 1'b1;
    r0.run_last     = !last_i;

    step_o.num           = {1'b0, have0} + {1'b0, last_i};
    step_o.res0          = have0 ? r0 : rline;
    step_o.res1          = rline;
    step_o.mode_nxt      = last_i ? MODE_SPACE : mode_mid;
    step_o.has_bytes_nxt = last_i ? 1'b0 : hb_mid;
  end

endmodule

// File: design/qts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_fifo
// Small result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module qts_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_num_i,
  input  qts_pkg::qts_res_t   wdata0_i,
  input  qts_pkg::qts_res_t   wdata1_i,
  input  logic                pop_i,
  output qts_pkg::qts_res_t   head_o,
  output qts_pkg::qts_qstat_t stat_o
);
  import qts_pkg::*;

  qts_res_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QPtrW-1:0] wr_ptr_p1;

  always_comb begin
    wr_ptr_p1 = wr_ptr_q + QPtrW'(1);
    wr_ptr_d  = wr_ptr_q + QPtrW'(push_num_i);
    rd_ptr_d  = rd_ptr_q + QPtrW'(pop_i);
    cnt_d     = cnt_q + QCntW'(push_num_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wdata0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= wdata1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.count     = cnt_q;
  assign stat_o.not_empty = (cnt_q != '0);

endmodule

// File: design/quoted_token_splitter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_token_splitter_core
// Splits a byte stream into whitespace or quote delimited tokens.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the input stage is not waiting. A
// byte goes into an input register and is parsed in the next cycle; its
// results (none, one or two) land in a four-entry result queue and leave
// through the output port one per cycle while the receiver is ready. The
// single output port sets the throughput: bytes that give at most one result
// flow at one per cycle, while a byte that gives both a result and the line
// end marker takes two output transfers. The input stage waits whenever the
// queue lacks room for two results.
module quoted_token_splitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       line_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       byte_valid_o,
  output logic       token_end_o,
  output logic       line_end_o,
  output logic       run_last_o
);
  import qts_pkg::*;

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  qts_mode_e  mode_q;
  logic       has_bytes_q;
  logic       advance;
  logic       pop;
  logic [1:0] push_num;
  qts_step_t  step;
  qts_res_t   head;
  qts_qstat_t qstat;

  // stage moves only when the queue can take a full two-result burst
  assign advance    = in_vld_q && (qstat.count <= QCntW'(QDepth - 2));
  assign in_ready_o = !in_vld_q || advance;
  assign pop        = out_valid_o && out_ready_i;
  assign push_num   = advance ? step.num : 2'd0;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_in_i;
      last_q <= line_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      mode_q      <= MODE_SPACE;
      has_bytes_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        mode_q      <= step.mode_nxt;
        has_bytes_q <= step.has_bytes_nxt;
      end
    end
  end

  qts_parse u_parse (
    .byte_i      (byte_q),
    .last_i      (last_q),
    .mode_i      (mode_q),
    .has_bytes_i (has_bytes_q),
    .step_o      (step)
  );

  qts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .wdata0_i   (step.res0),
    .wdata1_i   (step.res1),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  assign out_valid_o  = qstat.not_empty;
  assign byte_out_o   = head.byte_out;
  assign byte_valid_o = head.byte_valid;
  assign token_end_o  = head.token_end;
  assign line_end_o   = head.line_end;
  assign run_last_o   = head.run_last;

`ifndef SYNTHESIS
  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("result queue overflow");

  // a processed line end leaves the parser in space state with empty token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_q) |=> (mode_q == MODE_SPACE && !has_bytes_q))
    else $error("parser not reset after line end");

  // a popped line end result always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.line_end) |-> (head.run_last && !head.byte_valid))
    else $error("malformed line end result");
`endif

endmodule

// File: bench/token_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches both channels of the quoted token splitter. Every input transfer
// runs through a parse-state predictor that queues the expected token bytes
// and markers. Every output transfer is compared against the oldest entry.
// ----------------------------------------------------------------------------
module token_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  byte_in_i,
  input  logic        line_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  byte_out_i,
  input  logic        byte_valid_i,
  input  logic        token_end_i,
  input  logic        line_end_i,
  input  logic        run_last_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  import qts_pkg::*;

  qts_mode_e   parse_mode = MODE_SPACE;
  logic        token_open = 1'b0;
  qts_res_t    token_results_q[$];
  int unsigned mismatches = 0;
  int unsigned pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic qts_res_t make_res(logic [7:0] c, logic v, logic te, logic le);
    qts_res_t r;
    r            = '0;
    r.byte_out   = c;
    r.byte_valid = v;
    r.token_end  = te;
    r.line_end   = le;
    return r;
  endfunction

  // append one expected result at the tail
  task automatic add_expected(input qts_res_t r);
    token_results_q.insert(token_results_q.size(), r);
  endtask

  task automatic predict_tokens(input logic [7:0] ch, input logic last);
    int unsigned before_cnt;
    logic [7:0]  closer;
    qts_res_t    tail;
    before_cnt = token_results_q.size();
    case (parse_mode)
      MODE_SPACE: begin
        if (!is_blank(ch)) begin
          if (ch == CH_SQUOTE) begin
            parse_mode = MODE_SQUOTE;
            token_open = 1'b0;
          end else if (ch == CH_DQUOTE) begin
            parse_mode = MODE_DQUOTE;
            token_open = 1'b0;
          end else begin
            add_expected(make_res(ch, 1'b1, 1'b0, 1'b0));
            parse_mode = MODE_PLAIN;
            token_open = 1'b1;
          end
        end
      end
      MODE_PLAIN: begin
        if (is_blank(ch)) begin
          if (token_open) add_expected(make_res(8'h00, 1'b0, 1'b1, 1'b0));
          token_open = 1'b0;
          parse_mode = MODE_SPACE;
        end else begin
          add_expected(make_res(ch, 1'b1, 1'b0, 1'b0));
          token_open = 1'b1;
        end
      end
      default: begin
        closer = (parse_mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        if (ch == closer) begin
          // empty quotes close silently
          if (token_open) add_expected(make_res(8'h00, 1'b0, 1'b1, 1'b0));
          token_open = 1'b0;
          parse_mode = MODE_SPACE;
        end else begin
          add_expected(make_res(ch, 1'b1, 1'b0, 1'b0));
          token_open = 1'b1;
        end
      end
    endcase
    if (last) begin
      // line end also flushes a token left open, quoted or not
      add_expected(make_res(8'h00, 1'b0, token_open, 1'b1));
      token_open = 1'b0;
      parse_mode = MODE_SPACE;
    end
    if (token_results_q.size() > before_cnt) begin
      tail          = token_results_q[token_results_q.size() - 1];
      tail.run_last = 1'b1;
      token_results_q[token_results_q.size() - 1] = tail;
    end
  endtask

  task automatic check_result();
    qts_res_t got;
    qts_res_t want;
    got            = '0;
    got.byte_out   = byte_out_i;
    got.byte_valid = byte_valid_i;
    got.token_end  = token_end_i;
    got.line_end   = line_end_i;
    got.run_last   = run_last_i;
    if (token_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result byte=%02h bv=%0b te=%0b le=%0b rl=%0b",
                 $realtime, got.byte_out, got.byte_valid, got.token_end,
                 got.line_end, got.run_last);
    end else begin
      want = token_results_q.pop_front();
      if (got.byte_out !== want.byte_out || got.byte_valid !== want.byte_valid ||
          got.token_end !== want.token_end || got.line_end !== want.line_end ||
          got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp byte=%02h bv=%0b te=%0b le=%0b rl=%0b,",
                    " got byte=%02h bv=%0b te=%0b le=%0b rl=%0b"},
                   $realtime, want.byte_out, want.byte_valid, want.token_end,
                   want.line_end, want.run_last, got.byte_out, got.byte_valid,
                   got.token_end, got.line_end, got.run_last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_mode = MODE_SPACE;
      token_open = 1'b0;
      token_results_q.delete();
    end else begin
      // outputs first: a result never leaves in the cycle its byte arrives
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) predict_tokens(byte_in_i, line_last_i);
    end
    pending <= token_results_q.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for quoted_token_splitter_core. Sends a directed set of lines
// covering blanks, quotes, empty and unclosed quotes and byte extremes, then
// random lines built from words, quoted tokens, blank runs and noise. The
// sender bursts with gaps and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
  import qts_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in     = 8'h00;
  logic        line_last   = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  byte_out;
  logic        byte_valid;
  logic        token_end;
  logic        line_end;
  logic        run_last;
  int unsigned mismatch_count;
  int unsigned pending;

  int unsigned bytes_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_style = 0;
  logic [7:0]  stall_mask  = 8'hA5;

  always #5 clk = ~clk;

  quoted_token_splitter_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .byte_in_i    (byte_in),
    .line_last_i  (line_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .byte_out_o   (byte_out),
    .byte_valid_o (byte_valid),
    .token_end_o  (token_end),
    .line_end_o   (line_end),
    .run_last_o   (run_last)
  );

  token_stream_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .byte_in_i        (byte_in),
    .line_last_i      (line_last),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .byte_out_i       (byte_out),
    .byte_valid_i     (byte_valid),
    .token_end_i      (token_end),
    .line_end_i       (line_end),
    .run_last_i       (run_last),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // receiver: switch between stall styles at random
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_style <= $urandom_range(0, 3);
    stall_mask <= {stall_mask[6:0], stall_mask[7]};
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_mask[0];
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    logic        took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    byte_in   <= b;
    line_last <= last;
    // ready is settled by the falling edge and holds until the next rising one
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 0) ? 8'h20 : 8'(8'h08 + k);
  endfunction

  function automatic logic [7:0] pick_word_byte(input logic allow_quote);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b == 8'h20) || (b >= 8'h09 && b <= 8'h0D) ||
           (!allow_quote && (b == CH_SQUOTE || b == CH_DQUOTE)));
    return b;
  endfunction

  task automatic send_random_line();
    logic [7:0]  line_q[$];
    logic [7:0]  quote;
    logic [7:0]  b;
    int unsigned pieces;
    int unsigned kind;
    int unsigned n;
    pieces = $urandom_range(1, 6);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
        n = $urandom_range(1, 3);
        repeat (n) line_q.insert(line_q.size(), pick_blank());
      end else if (kind < 12) begin
        // plain word, quotes allowed after the first byte
        n = $urandom_range(1, 6);
        line_q.insert(line_q.size(), pick_word_byte(1'b0));
        repeat (n - 1)
          line_q.insert(line_q.size(), pick_word_byte($urandom_range(0, 3) == 0));
      end else if (kind < 17) begin
        quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_q.insert(line_q.size(), quote);
        n = $urandom_range(0, 5);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == quote) b = b ^ 8'h01;
          line_q.insert(line_q.size(), b);
        end
        if ($urandom_range(0, 9) != 0) line_q.insert(line_q.size(), quote);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blank-only line
    send_byte(8'h20, 1'b1);
    // byte extremes as one token, flushed at line end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // every control blank, the byte just below the blank range, empty quotes
    send_byte(8'h09, 1'b0);
    send_byte(8'h08, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_byte(8'h0B, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_byte(8'h0A, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    // double-quoted token with a blank inside, next token glued to the closer
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(8'h0E, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(8'h20, 1'b0);
    // unclosed quote flushed at line end
    send_byte(CH_DQUOTE, 1'b0);
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(8'h7A, 1'b1);
    // opening quote as last byte
    send_byte(CH_SQUOTE, 1'b1);
    // closing quote as last byte gives two results
    send_byte(CH_SQUOTE, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(CH_SQUOTE, 1'b1);

    wait_drained();

    while (bytes_sent < 1300) begin
      send_random_line();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("** quoted_token_splitter_core: PASSED **");
    end else begin
      $display("** quoted_token_splitter_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** quoted_token_splitter_core: FAILED **");
    $finish;
  end

endmodule
